// ----- rtl/core/rdft_pkg.sv -----
package rdft_pkg;

  // Level ceiling. Every level is held in 8 bits, so the ceiling saturates at 255.
  localparam int LEVEL_MAX = 255;
  localparam int LEVEL_W   = 8;
  localparam int TOP_LEVEL = (LEVEL_MAX > 255) ? 255 : LEVEL_MAX;

  localparam int OPC_W   = 3;
  localparam int PARAM_W = 9;
  localparam int TIME_W  = 32;

  // Input item layout on the slave stream, lowest bit first.
  localparam int IN_OPC_LSB   = 0;
  localparam int IN_PARAM_LSB = IN_OPC_LSB + OPC_W;
  localparam int IN_DUR_LSB   = IN_PARAM_LSB + PARAM_W;
  localparam int IN_NOW_LSB   = IN_DUR_LSB + TIME_W;
  localparam int IN_BITS      = IN_NOW_LSB + TIME_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Result layout on the master stream, lowest bit first.
  localparam int OUT_BITS    = LEVEL_W + 1 + LEVEL_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd2;

  // Opcodes as they arrive on the stream.
  localparam logic [OPC_W-1:0] OP_REFRESH = 3'd0;
  localparam logic [OPC_W-1:0] OP_ON      = 3'd1;
  localparam logic [OPC_W-1:0] OP_OFF     = 3'd2;
  localparam logic [OPC_W-1:0] OP_TOGGLE  = 3'd3;
  localparam logic [OPC_W-1:0] OP_SET     = 3'd4;
  localparam logic [OPC_W-1:0] OP_STEP    = 3'd5;
  localparam logic [OPC_W-1:0] OP_TICK    = 3'd6;

  // Fade interpolation: elapsed time times level difference, divided by the span.
  localparam int DVD_W = TIME_W + LEVEL_W;
  localparam int DIV_W = TIME_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_REFRESH,
    CMD_ON,
    CMD_OFF,
    CMD_TOGGLE,
    CMD_SET,
    CMD_STEP,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [PARAM_W-1:0] param;
    logic [TIME_W-1:0]         now;
    logic                      dur_nz;
    logic [TIME_W-1:0]         deadline;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               is_on;
    logic [LEVEL_W-1:0] level;
    logic               state_event;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_APPLY,
    ST_TOGGLE,
    ST_DONE
  } back_state_t;

  // Clamp a signed level to 0..TOP_LEVEL.
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [PARAM_W+1:0] v);
    logic [LEVEL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed((PARAM_W+2)'(TOP_LEVEL))) begin
      r = LEVEL_W'(TOP_LEVEL);
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/rdft_front.sv -----
// Front end: unpacks an incoming item, classifies the opcode and precomputes
// the deadline that any timed command would arm.
module rdft_front (
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rdft_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                              q_full,
  output logic                              push,
  output rdft_pkg::cmd_t                    cmd
);

  logic [rdft_pkg::OPC_W-1:0]  opcode;
  logic [rdft_pkg::TIME_W-1:0] duration;
  logic [rdft_pkg::TIME_W-1:0] now;
  rdft_pkg::cmd_kind_t         kind;

  assign opcode   = s_tdata[rdft_pkg::IN_OPC_LSB +: rdft_pkg::OPC_W];
  assign duration = s_tdata[rdft_pkg::IN_DUR_LSB +: rdft_pkg::TIME_W];
  assign now      = s_tdata[rdft_pkg::IN_NOW_LSB +: rdft_pkg::TIME_W];

  always_comb begin
    unique case (opcode)
      rdft_pkg::OP_REFRESH: kind = rdft_pkg::CMD_REFRESH;
      rdft_pkg::OP_ON:      kind = rdft_pkg::CMD_ON;
      rdft_pkg::OP_OFF:     kind = rdft_pkg::CMD_OFF;
      rdft_pkg::OP_TOGGLE:  kind = rdft_pkg::CMD_TOGGLE;
      rdft_pkg::OP_SET:     kind = rdft_pkg::CMD_SET;
      rdft_pkg::OP_STEP:    kind = rdft_pkg::CMD_STEP;
      rdft_pkg::OP_TICK:    kind = rdft_pkg::CMD_TICK;
      default:              kind = rdft_pkg::CMD_NOP;
    endcase
  end

  assign s_tready     = !q_full;
  assign push         = s_tvalid && !q_full;
  assign cmd.kind     = kind;
  assign cmd.param    = $signed(s_tdata[rdft_pkg::IN_PARAM_LSB +: rdft_pkg::PARAM_W]);
  assign cmd.now      = now;
  assign cmd.dur_nz   = (duration != '0);
  // Wraps modulo 2^32; a sum of zero reads later as "not armed".
  assign cmd.deadline = now + duration;

endmodule

// ----- rtl/core/rdft_queue.sv -----
// Short command queue that lets the front keep accepting while the back works.
module rdft_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rdft_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output rdft_pkg::cmd_t rd_cmd
);

  rdft_pkg::cmd_t                   entries [rdft_pkg::Q_DEPTH];
  logic [rdft_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [rdft_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [rdft_pkg::Q_CNT_W-1:0]     count;
  logic                             do_push;
  logic                             do_pop;

  assign full     = (count == rdft_pkg::Q_CNT_W'(rdft_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  function automatic logic [rdft_pkg::Q_PTR_W-1:0] bump(input logic [rdft_pkg::Q_PTR_W-1:0] p);
    logic [rdft_pkg::Q_PTR_W-1:0] r;
    if (p == rdft_pkg::Q_PTR_W'(rdft_pkg::Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/rdft_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle. The quotient
// shifts into the dividend register as the dividend shifts out.
module rdft_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rdft_pkg::DVD_W-1:0]   dividend,
  input  logic [rdft_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [rdft_pkg::DVD_W-1:0]   quotient
);

  logic [rdft_pkg::DVD_W-1:0]     quo;
  logic [rdft_pkg::DIV_W:0]       rem;
  logic [rdft_pkg::DIV_W-1:0]     dsr;
  logic [rdft_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [rdft_pkg::DIV_W:0]       rem_sh;
  logic                           ge;
  logic [rdft_pkg::DIV_W:0]       rem_next;

  assign rem_sh   = {rem[rdft_pkg::DIV_W-1:0], quo[rdft_pkg::DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign rem_next = ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= rdft_pkg::DIV_CNT_W'(rdft_pkg::DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[rdft_pkg::DVD_W-2:0], ge};
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == rdft_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/rdft_back.sv -----
// Back end: holds the channel state and configuration, carries out one
// command at a time and presents the result in an output register.
module rdft_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rdft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdft_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              cmd_valid,
  input  rdft_pkg::cmd_t                    cmd,
  output logic                              pop,
  output logic                              res_valid,
  input  logic                              res_ready,
  output rdft_pkg::res_t                    res
);

  localparam logic [rdft_pkg::LEVEL_W-1:0] TOP = rdft_pkg::LEVEL_W'(rdft_pkg::TOP_LEVEL);

  rdft_pkg::back_state_t state;
  rdft_pkg::back_state_t state_next;

  // Configuration.
  logic invert_output;
  logic pwm_mode;
  logic output_enabled;

  // Channel state.
  logic                          on_flag;
  logic [rdft_pkg::LEVEL_W-1:0]  cur_level;
  logic [rdft_pkg::LEVEL_W-1:0]  fade_from;
  logic [rdft_pkg::LEVEL_W-1:0]  fade_to;
  logic [rdft_pkg::TIME_W-1:0]   fade_start;
  logic [rdft_pkg::TIME_W-1:0]   fade_end;
  logic [rdft_pkg::TIME_W-1:0]   toggle_deadline;

  // Per-command working registers.
  rdft_pkg::cmd_t                c;
  logic                          ev;
  logic [rdft_pkg::DVD_W-1:0]    prod;
  logic [rdft_pkg::DIV_W-1:0]    span_r;

  logic                          div_start;
  logic                          div_done;
  logic [rdft_pkg::DVD_W-1:0]    quo;
  logic                          out_free;
  logic                          out_load;

  logic [rdft_pkg::TIME_W-1:0]   td_kept;
  logic signed [rdft_pkg::PARAM_W+1:0] p_ext;
  logic signed [rdft_pkg::PARAM_W+1:0] step_sum;
  logic [rdft_pkg::LEVEL_W-1:0]  target;
  logic [rdft_pkg::TIME_W-1:0]   elapsed;
  logic [rdft_pkg::TIME_W-1:0]   span;
  logic                          neg;
  logic [rdft_pkg::LEVEL_W-1:0]  mag;
  logic [rdft_pkg::DVD_W-1:0]    prod_c;
  logic                          fade_active;
  logic                          fade_over;
  logic [rdft_pkg::LEVEL_W-1:0]  headroom;
  logic                          q_big;
  logic [rdft_pkg::LEVEL_W-1:0]  interp;
  logic [rdft_pkg::LEVEL_W-1:0]  drive;

  // A level change keeps the auto-toggle only while its deadline lies ahead.
  assign td_kept  = (toggle_deadline <= c.now) ? '0 : toggle_deadline;

  assign p_ext    = (rdft_pkg::PARAM_W+2)'(c.param);
  assign step_sum = p_ext + $signed({2'b00, 1'b0, cur_level});
  assign target   = rdft_pkg::clamp_level((c.kind == rdft_pkg::CMD_STEP) ? step_sum : p_ext);

  assign elapsed     = c.now - fade_start;
  assign span        = fade_end - fade_start;
  assign neg         = (fade_to < fade_from);
  assign mag         = neg ? (fade_from - fade_to) : (fade_to - fade_from);
  assign prod_c      = rdft_pkg::DVD_W'(elapsed) * rdft_pkg::DVD_W'(mag);
  assign fade_active = (fade_end != '0);
  assign fade_over   = (c.now >= fade_end);

  // Offset the start level by the truncated quotient, clamped to 0..TOP.
  assign headroom = TOP - fade_from;
  assign q_big    = (quo[rdft_pkg::DVD_W-1:rdft_pkg::LEVEL_W] != '0);
  always_comb begin
    if (neg) begin
      interp = (q_big || (quo[rdft_pkg::LEVEL_W-1:0] > fade_from)) ? '0
             : (fade_from - quo[rdft_pkg::LEVEL_W-1:0]);
    end else begin
      interp = (q_big || (quo[rdft_pkg::LEVEL_W-1:0] > headroom)) ? TOP
             : (fade_from + quo[rdft_pkg::LEVEL_W-1:0]);
    end
  end

  always_comb begin
    if (!output_enabled) begin
      drive = '0;
    end else if (pwm_mode) begin
      if (on_flag) begin
        drive = invert_output ? (TOP - cur_level) : cur_level;
      end else begin
        drive = invert_output ? TOP : '0;
      end
    end else begin
      drive = {{(rdft_pkg::LEVEL_W-1){1'b0}}, on_flag ^ invert_output};
    end
  end

  assign out_free = !res_valid || res_ready;

  rdft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rdft_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = rdft_pkg::ST_DECIDE;
        end
      end
      rdft_pkg::ST_DECIDE: begin
        unique case (c.kind) inside
          rdft_pkg::CMD_SET, rdft_pkg::CMD_STEP: begin
            state_next = c.dur_nz ? rdft_pkg::ST_CHECK : rdft_pkg::ST_DONE;
          end
          rdft_pkg::CMD_TICK: state_next = rdft_pkg::ST_CHECK;
          default:            state_next = rdft_pkg::ST_DONE;
        endcase
      end
      rdft_pkg::ST_CHECK: begin
        if (fade_active && !fade_over && (span != '0)) begin
          state_next = rdft_pkg::ST_DIV_GO;
        end else begin
          state_next = rdft_pkg::ST_TOGGLE;
        end
      end
      rdft_pkg::ST_DIV_GO:   state_next = rdft_pkg::ST_DIV_WAIT;
      rdft_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = rdft_pkg::ST_APPLY;
        end
      end
      rdft_pkg::ST_APPLY:  state_next = rdft_pkg::ST_TOGGLE;
      rdft_pkg::ST_TOGGLE: state_next = rdft_pkg::ST_DONE;
      rdft_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = rdft_pkg::ST_IDLE;
        end
      end
      default: state_next = rdft_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop       = (state == rdft_pkg::ST_IDLE) && cmd_valid;
    div_start = (state == rdft_pkg::ST_DIV_GO);
    out_load  = (state == rdft_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdft_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_output  <= 1'b0;
      pwm_mode       <= 1'b0;
      output_enabled <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdft_pkg::REG_INVERT: invert_output  <= cfg_data[0];
        rdft_pkg::REG_PWM:    pwm_mode       <= cfg_data[0];
        rdft_pkg::REG_ENABLE: output_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command execution.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_flag         <= 1'b0;
      cur_level       <= '0;
      fade_from       <= '0;
      fade_to         <= '0;
      fade_start      <= '0;
      fade_end        <= '0;
      toggle_deadline <= '0;
      ev              <= 1'b0;
    end else begin
      case (state)
        rdft_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            c  <= cmd;
            ev <= 1'b0;
          end
        end
        rdft_pkg::ST_DECIDE: begin
          case (c.kind) inside
            rdft_pkg::CMD_REFRESH: begin
              toggle_deadline <= '0;
              ev              <= 1'b1;
            end
            rdft_pkg::CMD_ON, rdft_pkg::CMD_OFF, rdft_pkg::CMD_TOGGLE: begin
              if (c.kind == rdft_pkg::CMD_ON) begin
                on_flag <= 1'b1;
              end else if (c.kind == rdft_pkg::CMD_OFF) begin
                on_flag <= 1'b0;
              end else begin
                on_flag <= !on_flag;
              end
              toggle_deadline <= c.dur_nz ? c.deadline : '0;
              ev              <= 1'b1;
            end
            rdft_pkg::CMD_SET, rdft_pkg::CMD_STEP: begin
              if (c.dur_nz) begin
                fade_from  <= cur_level;
                fade_to    <= target;
                fade_start <= c.now;
                fade_end   <= c.deadline;
              end else begin
                cur_level       <= target;
                fade_end        <= '0;
                toggle_deadline <= td_kept;
                ev              <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        rdft_pkg::ST_CHECK: begin
          prod   <= prod_c;
          span_r <= span;
          if (fade_active) begin
            if (fade_over) begin
              fade_end <= '0;
              ev       <= 1'b1;
              if (fade_to != cur_level) begin
                cur_level       <= fade_to;
                toggle_deadline <= td_kept;
              end
            end else if (span == '0) begin
              if (fade_from != cur_level) begin
                cur_level       <= fade_from;
                toggle_deadline <= td_kept;
              end
            end
          end
        end
        rdft_pkg::ST_APPLY: begin
          if (interp != cur_level) begin
            cur_level       <= interp;
            toggle_deadline <= td_kept;
          end
        end
        rdft_pkg::ST_TOGGLE: begin
          if ((toggle_deadline != '0) && (c.now > toggle_deadline)) begin
            on_flag         <= !on_flag;
            toggle_deadline <= '0;
            ev              <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.drive_level <= drive;
      res.is_on       <= on_flag;
      res.level       <= cur_level;
      res.state_event <= ev;
    end
  end

endmodule

// ----- rtl/core/relay_dimmer_fade_timeout_top.sv -----
// Channel       | Direction | Handshake           | Payload
// s (commands)  | in        | s_tvalid / s_tready | s_tdata: opcode, param, duration_ms, now_ms
// m (results)   | out       | m_tvalid / m_tready | m_tdata: drive_level, is_on, level, state_event
// cfg           | in        | cfg_we              | cfg_index, cfg_data
//
// Every item gives exactly one result item. Refresh, on, off, toggle and an
// untimed set or step pass DECIDE and DONE in the back end; a tick or a timed set
// or step that needs no interpolation adds CHECK and TOGGLE; one that interpolates a
// fade adds DIV_GO, DIV_WAIT (40-step restoring divider, one quotient bit per cycle), APPLY.
// Reset is synchronous and active high; it clears the channel state, the queue
// and the configuration (output enabled, not inverted, digital mode).
// A two-entry command queue sits between the front and the back, so the input
// keeps accepting items while a result waits in the output register, until the
// queue is full.
module relay_dimmer_fade_timeout_top (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: index 0 invert_output, 1 pwm_mode, 2 output_enabled.
  input  logic                              cfg_we,
  input  logic [rdft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdft_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // From bit 0 up: opcode[2:0], param[11:3] (signed), duration_ms[43:12],
  // now_ms[75:44], zero fill.
  input  logic [rdft_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // From bit 0 up: drive_level[7:0], is_on[8], level[16:9], state_event[17],
  // zero fill.
  output logic [rdft_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  rdft_pkg::cmd_t front_cmd;
  rdft_pkg::cmd_t head_cmd;
  rdft_pkg::res_t res;
  logic           push;
  logic           q_full;
  logic           head_valid;
  logic           pop;

  // Front end: decode the item and precompute its deadline.
  rdft_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  // Decouples acceptance from execution.
  rdft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_cmd   (front_cmd),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (head_valid),
    .rd_cmd   (head_cmd)
  );

  // Back end: state, fade interpolation, auto-toggle and drive.
  rdft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {{(rdft_pkg::OUT_TDATA_W - rdft_pkg::OUT_BITS){1'b0}},
                    res.state_event, res.level, res.is_on, res.drive_level};

endmodule
